### hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// shared types, round constants and helper functions for the sha-256 hasher
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } sha_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic       take_byte;   // store incoming byte, count it
    logic       load;        // copy chain into working vars, clear round count
    logic       round;       // one compression round
    logic       fold;        // add working vars into chain
    logic       pad_mark;    // write 0x80 at fill position
    logic       pad_zero;    // write zero at fill position
    logic       pad_len;     // write length byte at fill position
    logic       reinit;      // restore initial chain, clear byte count and fill level
    logic       emit_next;   // advance output word
  } sha_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic       last_round;  // round 63 in progress
    logic [5:0] fill;        // current fill level
  } sha_stat_t;

  localparam logic [5:0] LenPos = 6'd56;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
          32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### hw/rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// sha-256 digest of a byte stream, eight digest words per message
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | data_byte, byte_valid, msg_end
//  out     | out_valid | out_stall | digest_word, word_index, last_word
//
// the input takes one byte a cycle while not stalled; a byte that completes a
// 64-byte block is compressed first (load, 64 rounds on the single round unit, fold)
// an end beat writes padding one byte a cycle, compresses one or two blocks,
// then shows eight digest words, one per beat
// input is stalled while a block compresses or padding/digest are in flight
// reset restores the initial chain and clears the byte count
module sha256_stream_hasher import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_valid_i,
  input  logic        msg_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_cmd_t  cmd;
  sha_stat_t stat;
  logic [2:0] widx;

  sha_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .byte_valid_i,
    .msg_end_i,
    .in_stall_o,
    .out_valid_o,
    .out_stall_i,
    .word_idx_i (widx),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  sha_dpath u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i         (cmd),
    .data_byte_i,
    .stat_o        (stat),
    .digest_word_o,
    .word_idx_o    (widx)
  );

  assign word_index_o = widx;
  assign last_word_o  = (widx == 3'd7);

  // buffer writes are exclusive
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.take_byte, cmd.pad_mark, cmd.pad_zero, cmd.pad_len}))
    else $error("more than one buffer write");

  // no rounds while output is shown
  a_no_round_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !cmd.round)
    else $error("round during output");

  // input is never taken while output is pending
  a_no_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open during output");

endmodule

### hw/rtl/sha_ctrl.sv
// ----------------------------------------------------------------------------
// sha_ctrl
// sequencer: byte intake, compression rounds, padding and digest output
// ----------------------------------------------------------------------------
module sha_ctrl import sha_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      byte_valid_i,
  input  logic      msg_end_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  logic [2:0] word_idx_i,
  input  sha_stat_t stat_i,
  output sha_cmd_t  cmd_o
);

  sha_state_e state_q, state_d;
  logic       end_q, end_d;     // padding pending after current block
  logic       mark_q, mark_d;   // 0x80 already written
  logic       len_q, len_d;     // length bytes going into this block

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      end_q   <= 1'b0;
      mark_q  <= 1'b0;
      len_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      mark_q  <= mark_d;
      len_q   <= len_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    end_d       = end_q;
    mark_d      = mark_q;
    len_d       = len_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take_byte = byte_valid_i;
          end_d = msg_end_i;
          // a byte that fills the block is compressed before padding
          if (byte_valid_i && stat_i.fill == 6'd63) begin
            state_d = ST_LOAD;
          end else if (msg_end_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        // zeros up to the length field, or to block end if the mark is at or past it
        if (!mark_q) begin
          cmd_o.pad_mark = 1'b1;
          mark_d = 1'b1;
        end else if (len_q || stat_i.fill == LenPos) begin
          cmd_o.pad_len = 1'b1;
          len_d = 1'b1;
        end else begin
          cmd_o.pad_zero = 1'b1;
        end
        if (stat_i.fill == 6'd63) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        if (stat_i.last_round) state_d = ST_FOLD;
      end
      ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (len_q) state_d = ST_EMIT;
        else if (end_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          cmd_o.emit_next = 1'b1;
          if (word_idx_i == 3'd7) begin
            cmd_o.reinit = 1'b1;
            end_d   = 1'b0;
            mark_d  = 1'b0;
            len_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### hw/rtl/sha_dpath.sv
// ----------------------------------------------------------------------------
// sha_dpath
// block words and schedule, round logic, chain words and byte count
// ----------------------------------------------------------------------------
module sha_dpath import sha_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  input  logic [7:0]  data_byte_i,
  output sha_stat_t   stat_o,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_idx_o
);

  logic [31:0] w_q [16];
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [60:0] total_q;
  logic [5:0]  fill_q;
  logic [5:0]  rnd_q;
  logic [2:0]  widx_q;

  logic [63:0] bits;
  logic [7:0]  wr_byte;
  logic        wr_en;
  logic [31:0] wt, w_new, x, y, s0, s1, t1, t2;
  logic [2:0]  len_sel;
  logic [4:0]  lane_lsb;

  assign bits     = {total_q, 3'b000};
  assign len_sel  = 3'd7 - fill_q[2:0];
  assign lane_lsb = {~fill_q[1:0], 3'b000};

  always_comb begin
    wr_en   = cmd_i.take_byte | cmd_i.pad_mark | cmd_i.pad_zero | cmd_i.pad_len;
    wr_byte = 8'h00;
    if (cmd_i.take_byte)      wr_byte = data_byte_i;
    else if (cmd_i.pad_mark)  wr_byte = 8'h80;
    else if (cmd_i.pad_len)   wr_byte = bits[{len_sel, 3'b000} +: 8];
  end

  // schedule as a shift line: w_q[0] is w[t]
  always_comb begin
    x     = w_q[1];
    y     = w_q[14];
    s0    = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    s1    = rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10);
    w_new = w_q[0] + s0 + w_q[9] + s1;
    wt    = w_q[0];
    t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25)) +
         ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + round_k(rnd_q) + wt;
    t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i) begin
    // bytes land big-endian straight in the schedule words
    if (wr_en) begin
      w_q[fill_q[5:2]][lane_lsb +: 8] <= wr_byte;
    end else if (cmd_i.round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.round) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
      total_q <= '0;
      fill_q  <= '0;
      rnd_q   <= '0;
      widx_q  <= '0;
    end else begin
      if (wr_en) fill_q <= fill_q + 6'd1;
      if (cmd_i.take_byte) total_q <= total_q + 61'd1;
      if (cmd_i.load) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.fold) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end
      if (cmd_i.emit_next) widx_q <= widx_q + 3'd1;
      if (cmd_i.reinit) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_h(3'(i));
        total_q <= '0;
        fill_q  <= '0;
      end
    end
  end

  assign stat_o.last_round = (rnd_q == 6'd63);
  assign stat_o.fill       = fill_q;
  assign digest_word_o     = h_q[widx_q];
  assign word_idx_o        = widx_q;

endmodule
